// ===== rtl/core/sacch_power_and_ta_loops_assert.svh =====
// Assertion macros shared by the SACCH loop RTL
`ifndef SACCH_POWER_AND_TA_LOOPS_ASSERT_SVH
`define SACCH_POWER_AND_TA_LOOPS_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define SACCH_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sacch assertion failed");

// next-cycle implication, checked on every rising edge out of reset
`define SACCH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sacch assertion failed");

`endif

// ===== rtl/core/sacch_pkg.sv =====
// Package: constants, codes and types of the SACCH power and timing advance loops
`timescale 1ns / 1ps
`default_nettype none

package sacch_pkg;

    localparam int CHANNELS   = 64;
    localparam int RSSI_SLOTS = 32;
    localparam int TOA_FRAMES = 16;

    localparam int CH_W       = 6;
    localparam int RSSI_W     = 8;
    localparam int TOA_W      = 16;
    localparam int RTA_W      = 8;
    localparam int LEVEL_W    = 5;
    localparam int TA_W       = 6;
    localparam int CARRIER_W  = 10;
    localparam int STEP_W     = 5;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 3;

    localparam int RAM_DEPTH  = (CHANNELS < (2 ** CH_W)) ? CHANNELS : (2 ** CH_W);
    localparam int CH_IDX_W   = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
    localparam int RCNT_W     = $clog2(RSSI_SLOTS + 1);
    localparam int TCNT_W     = $clog2(TOA_FRAMES);
    localparam int ACC_W      = TOA_W + $clog2(TOA_FRAMES);

    localparam int BAND_LOW    = 512;
    localparam int BAND_HIGH   = 885;
    localparam int CAP_NARROW  = 15;
    localparam int CAP_WIDE    = 19;
    localparam int DUMMY_LIMIT = -127;
    localparam int TOA_LIMIT   = 230;
    localparam int TA_TOP      = 63;
    localparam int RSSI_IDLE   = 127;
    localparam int TOA_THRESH  = (TOA_LIMIT + 1) * TOA_FRAMES;

    localparam logic signed [RSSI_W-1:0] RSSI_FLOOR = RSSI_W'(DUMMY_LIMIT);
    localparam logic signed [ACC_W-1:0]  TOA_SUM_HI = ACC_W'(TOA_THRESH);
    localparam logic signed [ACC_W-1:0]  TOA_SUM_LO = ACC_W'(-TOA_THRESH);

    localparam int OUTQ_DEPTH = 3;
    localparam int OUTQ_PTR_W = 2;
    localparam int OUTQ_CNT_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POWER_EN = 3'd0,
        CFG_TA_EN    = 3'd1,
        CFG_TARGET   = 3'd2,
        CFG_CARRIER  = 3'd3,
        CFG_RAISE    = 3'd4,
        CFG_LOWER    = 3'd5
    } cfg_index_t;

    typedef enum logic {
        CMD_MEAS = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    typedef struct packed {
        logic                     power_en;
        logic                     ta_en;
        logic signed [RSSI_W-1:0] target;
        logic [CARRIER_W-1:0]     carrier;
        logic [STEP_W-1:0]        raise_max;
        logic [STEP_W-1:0]        lower_max;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]       level;
        logic [TA_W-1:0]          adv;
        logic                     parity;
        logic                     first_seen;
        logic                     since_eval;
        logic [RCNT_W-1:0]        rtaken;
        logic signed [RSSI_W-1:0] rlowest;
        logic signed [ACC_W-1:0]  taccum;
        logic [TCNT_W-1:0]        ttaken;
    } entry_t;

    typedef struct packed {
        logic [CH_W-1:0]    out_channel;
        logic [LEVEL_W-1:0] power_level;
        logic [TA_W-1:0]    ordered_ta;
        logic               power_changed;
        logic               ta_changed;
    } result_t;

    localparam entry_t ENTRY_RESET = '{
        level:      '0,
        adv:        '0,
        parity:     1'b0,
        first_seen: 1'b0,
        since_eval: 1'b0,
        rtaken:     '0,
        rlowest:    RSSI_W'(RSSI_IDLE),
        taccum:     '0,
        ttaken:     '0
    };

endpackage

`default_nettype wire

// ===== rtl/core/sacch_state_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none

module sacch_state_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sacch_loop_calc.sv =====
// Update of one channel entry: RSSI collection, TOA averaging and power step
`timescale 1ns / 1ps
`default_nettype none

module sacch_loop_calc
    import sacch_pkg::*;
(
    input  wire cmd_t                     cmd,
    input  wire logic signed [RSSI_W-1:0] rssi,
    input  wire logic signed [TOA_W-1:0]  toa,
    input  wire logic [RTA_W-1:0]         rep_ta,
    input  wire cfg_t                     cfg,
    input  wire entry_t                   cur,
    output entry_t                        nxt,
    output logic                          power_changed,
    output logic                          ta_changed
);

    logic signed [ACC_W-1:0]  toa_sum;
    logic [TCNT_W:0]          toa_cnt;
    logic                     step_en;
    logic signed [8:0]        diff;
    logic signed [8:0]        half;
    logic signed [10:0]       cur_s;
    logic signed [10:0]       nw;
    logic signed [10:0]       cap_s;
    logic signed [10:0]       up_s;
    logic signed [10:0]       dn_s;
    logic                     narrow_band;

    assign narrow_band = (cfg.carrier >= CARRIER_W'(BAND_LOW))
                      && (cfg.carrier <= CARRIER_W'(BAND_HIGH));
    assign cap_s = narrow_band ? 11'(CAP_NARROW) : 11'(CAP_WIDE);
    assign cur_s = $signed({6'b0, cur.level});
    assign up_s  = cur_s + $signed({6'b0, cfg.lower_max});
    assign dn_s  = cur_s - $signed({6'b0, cfg.raise_max});
    assign toa_sum = cur.taccum + $signed({{(ACC_W - TOA_W){toa[TOA_W-1]}}, toa});
    assign toa_cnt = {1'b0, cur.ttaken} + (TCNT_W + 1)'(1);

    always_comb begin
        nxt     = cur;
        step_en = 1'b0;
        diff    = '0;
        if (cmd == CMD_MEAS) begin
            if (cfg.power_en && (rssi >= RSSI_FLOOR)) begin
                nxt.first_seen = 1'b1;
                nxt.since_eval = 1'b1;
                if (cur.rtaken < RCNT_W'(RSSI_SLOTS)) begin
                    if (rssi < cur.rlowest) begin
                        nxt.rlowest = rssi;
                    end
                    nxt.rtaken = cur.rtaken + RCNT_W'(1);
                end
            end
            if (cfg.ta_en && ({(RTA_W - TA_W)'(0), cur.adv} == rep_ta)) begin
                if (toa_cnt >= (TCNT_W + 1)'(TOA_FRAMES)) begin
                    if ((toa_sum <= TOA_SUM_LO) && (cur.adv != '0)) begin
                        nxt.adv = cur.adv - TA_W'(1);
                    end else if ((toa_sum >= TOA_SUM_HI) && (cur.adv < TA_W'(TA_TOP))) begin
                        nxt.adv = cur.adv + TA_W'(1);
                    end
                    nxt.taccum = '0;
                    nxt.ttaken = '0;
                end else begin
                    nxt.taccum = toa_sum;
                    nxt.ttaken = toa_cnt[TCNT_W-1:0];
                end
            end
        end else begin
            if (cfg.power_en && cur.parity && cur.first_seen) begin
                if (!cur.since_eval) begin
                    step_en = 1'b1;
                    diff    = $signed({4'b0, cfg.raise_max});
                end else begin
                    nxt.since_eval = 1'b0;
                    if (cur.rtaken != '0) begin
                        step_en     = 1'b1;
                        diff        = $signed({cfg.target[RSSI_W-1], cfg.target})
                                    - $signed({cur.rlowest[RSSI_W-1], cur.rlowest});
                        nxt.rtaken  = '0;
                        nxt.rlowest = RSSI_W'(RSSI_IDLE);
                    end
                end
            end
            nxt.parity = ~cur.parity;
        end

        half = diff >>> 1;
        nw   = cur_s - {{2{half[8]}}, half};
        if (nw < 11'sd0) begin
            nw = 11'sd0;
        end
        if (nw > cap_s) begin
            nw = cap_s;
        end
        if (nw > up_s) begin
            nw = up_s;
        end else if (nw < dn_s) begin
            nw = dn_s;
        end
        if (step_en && (diff != 9'sd0)) begin
            nxt.level = nw[LEVEL_W-1:0];
        end
    end

    assign power_changed = (nxt.level != cur.level);
    assign ta_changed    = (nxt.adv != cur.adv);

endmodule

`default_nettype wire

// ===== rtl/core/sacch_out_queue.sv =====
// Three-entry result queue between the update stage and the result channel
`timescale 1ns / 1ps
`default_nettype none

module sacch_out_queue
    import sacch_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire result_t               push_data,
    input  wire logic                  m_ready,
    output logic                       m_valid,
    output result_t                    head_data,
    output logic [OUTQ_CNT_W-1:0]      count
);

`include "sacch_power_and_ta_loops_assert.svh"

    result_t                 slots [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]   head_reg;
    logic [OUTQ_PTR_W-1:0]   head_next;
    logic [OUTQ_PTR_W-1:0]   tail_reg;
    logic [OUTQ_PTR_W-1:0]   tail_next;
    logic [OUTQ_CNT_W-1:0]   count_reg;
    logic [OUTQ_CNT_W-1:0]   count_next;
    logic                    pop;

    assign m_valid   = (count_reg != '0);
    assign pop       = m_valid && m_ready;
    assign head_data = slots[head_reg];
    assign count     = count_reg;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (pop) begin
            head_next = (head_reg == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push) begin
            tail_next = (tail_reg == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[tail_reg] <= push_data;
        end
    end

    `SACCH_ASSERT_NOW(a_no_overflow, push, count_reg < OUTQ_CNT_W'(OUTQ_DEPTH))
    `SACCH_ASSERT_NEXT(a_pop_drains, pop && !push, count_reg == $past(count_reg) - 1'b1)
    `SACCH_ASSERT_NOW(a_ptrs_agree, count_reg == '0, head_reg == tail_reg)

endmodule

`default_nettype wire

// ===== rtl/core/sacch_power_and_ta_loops.sv =====
// Top level of the per-channel SACCH power control and timing advance loops
// One item per cycle sustained while the result queue has room; each result is registered into the queue.
// Each item reads its channel entry from the state RAM (registered read), is updated in the
// following cycle and written back; an item on the same channel right behind it takes the
// fresh entry from a one-deep forward register. The three-entry result queue keeps input
// acceptance going while results wait. No clearing pass after reset: per-channel valid bits
// make untouched entries read as their reset value, so items are taken at once.
`timescale 1ns / 1ps
`default_nettype none

module sacch_power_and_ta_loops
    import sacch_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,

    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_wdata,

    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic                     s_cmd,
    input  wire logic [CH_W-1:0]          s_channel,
    input  wire logic signed [RSSI_W-1:0] s_rssi,
    input  wire logic signed [TOA_W-1:0]  s_toa256,
    input  wire logic [RTA_W-1:0]         s_reported_ta,

    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [CH_W-1:0]               m_out_channel,
    output logic [LEVEL_W-1:0]            m_power_level,
    output logic [TA_W-1:0]               m_ordered_ta,
    output logic                          m_power_changed,
    output logic                          m_ta_changed
);

`include "sacch_power_and_ta_loops_assert.svh"

    cfg_t                     cfg_reg;
    cfg_t                     cfg_next;

    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    cmd_t                     s1_cmd_reg;
    logic [CH_W-1:0]          s1_ch_reg;
    logic signed [RSSI_W-1:0] s1_rssi_reg;
    logic signed [TOA_W-1:0]  s1_toa_reg;
    logic [RTA_W-1:0]         s1_rep_reg;

    logic [RAM_DEPTH-1:0]     chan_valid_reg;
    logic [RAM_DEPTH-1:0]     chan_valid_next;
    logic                     fwd_valid_reg;
    logic                     fwd_valid_next;
    logic [CH_IDX_W-1:0]      fwd_ch_reg;
    entry_t                   fwd_data_reg;

    logic                     accept;
    logic                     in_range;
    logic                     wr_en;
    logic [CH_IDX_W-1:0]      s1_idx;
    logic [$bits(entry_t)-1:0] ram_rdata;
    entry_t                   cur_entry;
    entry_t                   nxt_entry;
    logic                     power_changed;
    logic                     ta_changed;
    logic                     ta_step_ok;
    result_t                  s1_result;
    result_t                  head_result;
    logic [OUTQ_CNT_W-1:0]    q_count;

    assign accept = s_valid && s_ready;
    assign s_ready = ({2'b0, s1_valid_reg} + {1'b0, q_count}) < 3'(OUTQ_DEPTH);

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_POWER_EN: cfg_next.power_en  = cfg_wdata[0];
                CFG_TA_EN:    cfg_next.ta_en     = cfg_wdata[0];
                CFG_TARGET:   cfg_next.target    = $signed(cfg_wdata[RSSI_W-1:0]);
                CFG_CARRIER:  cfg_next.carrier   = cfg_wdata[CARRIER_W-1:0];
                CFG_RAISE:    cfg_next.raise_max = cfg_wdata[STEP_W-1:0];
                CFG_LOWER:    cfg_next.lower_max = cfg_wdata[STEP_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.power_en  <= 1'b0;
            cfg_reg.ta_en     <= 1'b0;
            cfg_reg.target    <= -8'sd10;
            cfg_reg.carrier   <= '0;
            cfg_reg.raise_max <= STEP_W'(4);
            cfg_reg.lower_max <= STEP_W'(2);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s1_idx   = s1_ch_reg[CH_IDX_W-1:0];
    assign in_range = ({3'b0, s1_ch_reg} < 9'(CHANNELS));
    assign wr_en    = s1_valid_reg && in_range;

    assign s1_valid_next  = accept;
    assign fwd_valid_next = wr_en;

    always_comb begin
        chan_valid_next = chan_valid_reg;
        if (wr_en) begin
            chan_valid_next[s1_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            chan_valid_reg <= '0;
        end else begin
            s1_valid_reg   <= s1_valid_next;
            fwd_valid_reg  <= fwd_valid_next;
            chan_valid_reg <= chan_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_cmd_reg  <= cmd_t'(s_cmd);
            s1_ch_reg   <= s_channel;
            s1_rssi_reg <= s_rssi;
            s1_toa_reg  <= s_toa256;
            s1_rep_reg  <= s_reported_ta;
        end
        if (wr_en) begin
            fwd_ch_reg   <= s1_idx;
            fwd_data_reg <= nxt_entry;
        end
    end

    sacch_state_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (RAM_DEPTH),
        .ADDR_W(CH_IDX_W)
    ) u_state_ram (
        .aclk (aclk),
        .we   (wr_en),
        .waddr(s1_idx),
        .wdata(nxt_entry),
        .re   (accept),
        .raddr(s_channel[CH_IDX_W-1:0]),
        .rdata(ram_rdata)
    );

    always_comb begin
        if (fwd_valid_reg && (fwd_ch_reg == s1_idx)) begin
            cur_entry = fwd_data_reg;
        end else if (chan_valid_reg[s1_idx]) begin
            cur_entry = entry_t'(ram_rdata);
        end else begin
            cur_entry = ENTRY_RESET;
        end
    end

    sacch_loop_calc u_loop_calc (
        .cmd          (s1_cmd_reg),
        .rssi         (s1_rssi_reg),
        .toa          (s1_toa_reg),
        .rep_ta       (s1_rep_reg),
        .cfg          (cfg_reg),
        .cur          (cur_entry),
        .nxt          (nxt_entry),
        .power_changed(power_changed),
        .ta_changed   (ta_changed)
    );

    always_comb begin
        s1_result.out_channel = s1_ch_reg;
        if (in_range) begin
            s1_result.power_level   = nxt_entry.level;
            s1_result.ordered_ta    = nxt_entry.adv;
            s1_result.power_changed = power_changed;
            s1_result.ta_changed    = ta_changed;
        end else begin
            s1_result.power_level   = '0;
            s1_result.ordered_ta    = '0;
            s1_result.power_changed = 1'b0;
            s1_result.ta_changed    = 1'b0;
        end
    end

    sacch_out_queue u_out_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (s1_valid_reg),
        .push_data(s1_result),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .head_data(head_result),
        .count    (q_count)
    );

    assign m_out_channel   = head_result.out_channel;
    assign m_power_level   = head_result.power_level;
    assign m_ordered_ta    = head_result.ordered_ta;
    assign m_power_changed = head_result.power_changed;
    assign m_ta_changed    = head_result.ta_changed;

    assign ta_step_ok = (nxt_entry.adv == cur_entry.adv)
                     || (nxt_entry.adv == cur_entry.adv + 1'b1)
                     || (nxt_entry.adv == cur_entry.adv - 1'b1);

    `SACCH_ASSERT_NOW(a_credit, s1_valid_reg, q_count < OUTQ_CNT_W'(OUTQ_DEPTH))
    `SACCH_ASSERT_NEXT(a_fwd_follows_write, wr_en, fwd_valid_reg && (fwd_ch_reg == $past(s1_idx)))
    `SACCH_ASSERT_NOW(a_ta_single_step, s1_valid_reg, ta_step_ok)

endmodule

`default_nettype wire

// ===== bench/tb_sacch_power_and_ta_loops.sv =====
// Testbench of the SACCH power control and timing advance loops: directed rows, random items
`timescale 1ns / 1ps

module tb_sacch_power_and_ta_loops;
    import sacch_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_LEN     = 300;
    localparam int PRESET_ROWS  = 4;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 230;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        cmd_t                     cmd;
        logic [CH_W-1:0]          ch;
        logic signed [RSSI_W-1:0] rssi;
        logic signed [TOA_W-1:0]  toa;
        logic [RTA_W-1:0]         rep;
    } burst_item_t;

    typedef struct {
        burst_item_t it;
        bit          typed;
        result_t     want;
    } stim_row_t;

    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index     = '0;
    logic [CFG_DATA_W-1:0]    cfg_wdata     = '0;
    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    logic                     s_cmd         = 1'b0;
    logic [CH_W-1:0]          s_channel     = '0;
    logic signed [RSSI_W-1:0] s_rssi        = '0;
    logic signed [TOA_W-1:0]  s_toa256      = '0;
    logic [RTA_W-1:0]         s_reported_ta = '0;
    logic                     m_valid;
    logic                     m_ready       = 1'b0;
    logic [CH_W-1:0]          m_out_channel;
    logic [LEVEL_W-1:0]       m_power_level;
    logic [TA_W-1:0]          m_ordered_ta;
    logic                     m_power_changed;
    logic                     m_ta_changed;

    cfg_t                     model_cfg;
    logic [LEVEL_W-1:0]       level_mem  [CHANNELS];
    logic [TA_W-1:0]          adv_mem    [CHANNELS];
    logic                     parity_mem [CHANNELS];
    logic                     seen_mem   [CHANNELS];
    logic                     fresh_mem  [CHANNELS];
    logic [RCNT_W-1:0]        rcount_mem [CHANNELS];
    logic signed [RSSI_W-1:0] rmin_mem   [CHANNELS];
    logic signed [ACC_W-1:0]  tsum_mem   [CHANNELS];
    logic [TCNT_W-1:0]        tcount_mem [CHANNELS];

    result_t   pending_q[$];
    stim_row_t dir_tab[$];
    int        err_cnt      = 0;
    int        idle_cnt     = 0;
    int        hold_cnt     = 0;
    int        rx_stall_pct = 0;
    bit        pressure_on  = 1'b0;

    always #5 aclk = ~aclk;

    sacch_power_and_ta_loops uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_channel       (s_channel),
        .s_rssi          (s_rssi),
        .s_toa256        (s_toa256),
        .s_reported_ta   (s_reported_ta),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_channel   (m_out_channel),
        .m_power_level   (m_power_level),
        .m_ordered_ta    (m_ordered_ta),
        .m_power_changed (m_power_changed),
        .m_ta_changed    (m_ta_changed)
    );

    function automatic logic [LEVEL_W-1:0] stepped_level(input int cur, input int diff);
        int half;
        int nw;
        int cap;
        if (diff == 0) begin
            return LEVEL_W'(cur);
        end
        half = (diff >= 0) ? diff / 2 : -((-diff + 1) / 2);
        nw = cur - half;
        if (nw < 0) begin
            nw = 0;
        end
        cap = (int'(model_cfg.carrier) >= BAND_LOW && int'(model_cfg.carrier) <= BAND_HIGH)
            ? CAP_NARROW : CAP_WIDE;
        if (nw > cap) begin
            nw = cap;
        end
        if (nw > cur + int'(model_cfg.lower_max)) begin
            nw = cur + int'(model_cfg.lower_max);
        end else if (nw < cur - int'(model_cfg.raise_max)) begin
            nw = cur - int'(model_cfg.raise_max);
        end
        return LEVEL_W'(nw);
    endfunction

    function automatic result_t advance_loops(input burst_item_t it);
        int      ch;
        int      cur_lvl;
        int      old_adv;
        int      rssi_v;
        int      sum;
        int      n;
        int      avg;
        int      diff;
        result_t r;
        ch      = it.ch;
        cur_lvl = level_mem[ch];
        old_adv = adv_mem[ch];
        rssi_v  = it.rssi;
        if (it.cmd == CMD_MEAS) begin
            if (model_cfg.power_en && rssi_v >= DUMMY_LIMIT) begin
                seen_mem[ch]  = 1'b1;
                fresh_mem[ch] = 1'b1;
                if (int'(rcount_mem[ch]) < RSSI_SLOTS) begin
                    if (rssi_v < int'(rmin_mem[ch])) begin
                        rmin_mem[ch] = it.rssi;
                    end
                    rcount_mem[ch] = rcount_mem[ch] + 1'b1;
                end
            end
            if (model_cfg.ta_en && int'(it.rep) == int'(adv_mem[ch])) begin
                sum = int'(tsum_mem[ch]) + int'(it.toa);
                n   = int'(tcount_mem[ch]) + 1;
                if (n >= TOA_FRAMES) begin
                    avg = sum / n;
                    if (avg < -TOA_LIMIT && adv_mem[ch] > 0) begin
                        adv_mem[ch] = adv_mem[ch] - 1'b1;
                    end else if (avg > TOA_LIMIT && int'(adv_mem[ch]) < TA_TOP) begin
                        adv_mem[ch] = adv_mem[ch] + 1'b1;
                    end
                    tsum_mem[ch]   = '0;
                    tcount_mem[ch] = '0;
                end else begin
                    tsum_mem[ch]   = ACC_W'(sum);
                    tcount_mem[ch] = TCNT_W'(n);
                end
            end
        end else begin
            if (model_cfg.power_en && parity_mem[ch] && seen_mem[ch]) begin
                if (!fresh_mem[ch]) begin
                    level_mem[ch] = stepped_level(cur_lvl, int'(model_cfg.raise_max));
                end else begin
                    fresh_mem[ch] = 1'b0;
                    if (rcount_mem[ch] != 0) begin
                        diff = int'(model_cfg.target) - int'(rmin_mem[ch]);
                        rcount_mem[ch] = '0;
                        rmin_mem[ch]   = RSSI_W'(RSSI_IDLE);
                        level_mem[ch]  = stepped_level(cur_lvl, diff);
                    end
                end
            end
            parity_mem[ch] = ~parity_mem[ch];
        end
        r.out_channel   = it.ch;
        r.power_level   = level_mem[ch];
        r.ordered_ta    = adv_mem[ch];
        r.power_changed = (int'(level_mem[ch]) != cur_lvl);
        r.ta_changed    = (int'(adv_mem[ch]) != old_adv);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        err_cnt++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        case (idx)
            CFG_POWER_EN: model_cfg.power_en  = value[0];
            CFG_TA_EN:    model_cfg.ta_en     = value[0];
            CFG_TARGET:   model_cfg.target    = value[RSSI_W-1:0];
            CFG_CARRIER:  model_cfg.carrier   = value[CARRIER_W-1:0];
            CFG_RAISE:    model_cfg.raise_max = value[STEP_W-1:0];
            CFG_LOWER:    model_cfg.lower_max = value[STEP_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic apply_setting(input int pe, input int te, input int target,
                                 input int carrier, input int raise, input int lower);
        write_reg(CFG_POWER_EN, pe);
        write_reg(CFG_TA_EN, te);
        write_reg(CFG_TARGET, target);
        write_reg(CFG_CARRIER, carrier);
        write_reg(CFG_RAISE, raise);
        write_reg(CFG_LOWER, lower);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic send_item(input burst_item_t it, input bit typed, input result_t want);
        result_t r;
        s_valid       <= 1'b1;
        s_cmd         <= it.cmd;
        s_channel     <= it.ch;
        s_rssi        <= it.rssi;
        s_toa256      <= it.toa;
        s_reported_ta <= it.rep;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        r = advance_loops(it);
        pending_q.push_back(typed ? want : r);
    endtask

    always @(posedge aclk) begin
        if (pressure_on && hold_cnt < HOLD_LEN) begin
            m_ready  <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            if (!pressure_on) begin
                hold_cnt <= 0;
            end
        end
    end

    always @(posedge aclk) begin
        result_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                report_mismatch("result with nothing pending, channel", m_out_channel, -1);
            end else begin
                w = pending_q.pop_front();
                if (m_out_channel != w.out_channel)
                    report_mismatch("out_channel", m_out_channel, w.out_channel);
                if (m_power_level != w.power_level)
                    report_mismatch("power_level", m_power_level, w.power_level);
                if (m_ordered_ta != w.ordered_ta)
                    report_mismatch("ordered_ta", m_ordered_ta, w.ordered_ta);
                if (m_power_changed != w.power_changed)
                    report_mismatch("power_changed", m_power_changed, w.power_changed);
                if (m_ta_changed != w.ta_changed)
                    report_mismatch("ta_changed", m_ta_changed, w.ta_changed);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
        if (idle_cnt >= STALL_LIMIT) begin
            $display("TIMEOUT: no handshake for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        burst_item_t it;
        result_t     none;
        int          tx_idle_pct;
        int          tick_pct;
        int          toa_bias;
        int          gap;
        int          roll;
        int          rv;
        int          tv;

        none = '0;
        model_cfg = '{power_en: 1'b0, ta_en: 1'b0, target: -8'sd10, carrier: '0,
                      raise_max: 5'd4, lower_max: 5'd2};
        for (int c = 0; c < CHANNELS; c++) begin
            level_mem[c]  = '0;
            adv_mem[c]    = '0;
            parity_mem[c] = 1'b0;
            seen_mem[c]   = 1'b0;
            fresh_mem[c]  = 1'b0;
            rcount_mem[c] = '0;
            rmin_mem[c]   = RSSI_W'(RSSI_IDLE);
            tsum_mem[c]   = '0;
            tcount_mem[c] = '0;
        end

        // loops off after reset: every result reads back zero level and advance, no change flags
        dir_tab.push_back('{'{CMD_MEAS, 6'd0, 8'h7f, 16'h7fff, 8'd0}, 1'b1,
                            '{6'd0, 5'd0, 6'd0, 1'b0, 1'b0}});
        dir_tab.push_back('{'{CMD_MEAS, 6'd63, 8'h80, 16'h8000, 8'd255}, 1'b1,
                            '{6'd63, 5'd0, 6'd0, 1'b0, 1'b0}});
        dir_tab.push_back('{'{CMD_TICK, 6'd5, 8'h00, 16'h0000, 8'd0}, 1'b1,
                            '{6'd5, 5'd0, 6'd0, 1'b0, 1'b0}});
        dir_tab.push_back('{'{CMD_TICK, 6'd5, 8'h00, 16'h0000, 8'd0}, 1'b1,
                            '{6'd5, 5'd0, 6'd0, 1'b0, 1'b0}});
        // full averaging window on the top arrival time, dummy burst included
        for (int i = 0; i < TOA_FRAMES; i++) begin
            it = '{CMD_MEAS, 6'd1, 8'h00, 16'h7fff, 8'd0};
            it.rssi = (i == 0) ? 8'sd127 : (i == 1) ? -8'sd127 : (i == 2) ? 8'h80
                    : RSSI_W'(-60 - i);
            dir_tab.push_back('{it, 1'b0, none});
        end
        // strong burst lowers power, then a lost period raises it again
        dir_tab.push_back('{'{CMD_MEAS, 6'd2, 8'sd40, 16'h0000, 8'd0}, 1'b0, none});
        dir_tab.push_back('{'{CMD_TICK, 6'd2, 8'h00, 16'h0000, 8'd0}, 1'b0, none});
        dir_tab.push_back('{'{CMD_TICK, 6'd2, 8'h00, 16'h0000, 8'd0}, 1'b0, none});
        dir_tab.push_back('{'{CMD_TICK, 6'd2, 8'h00, 16'h0000, 8'd0}, 1'b0, none});
        dir_tab.push_back('{'{CMD_TICK, 6'd2, 8'h00, 16'h0000, 8'd0}, 1'b0, none});

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) begin
            if (i == PRESET_ROWS) begin
                drain_results();
                write_reg(CFG_SPARE_LO, 1023);
                write_reg(CFG_SPARE_HI, 1023);
                apply_setting(1, 1, -10, 0, 4, 2);
            end
            send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            tx_idle_pct = 0;
            case (ph)
                0: begin
                    rx_stall_pct <= 0;
                    apply_setting(1, 1, -10, 600, 4, 2);
                end
                1: begin
                    tx_idle_pct = 87;
                    rx_stall_pct <= 0;
                    apply_setting(1, 1, -128, 512, 31, 31);
                end
                2: begin
                    rx_stall_pct <= 87;
                    apply_setting(1, 1, 0, 885, 0, 0);
                end
                3: begin
                    tx_idle_pct = 26;
                    rx_stall_pct <= 26;
                    apply_setting(1, 1, -int'($urandom_range(0, 128)), 886,
                                  $urandom_range(0, 31), $urandom_range(0, 31));
                end
                4: begin
                    rx_stall_pct <= 0;
                    pressure_on  <= 1'b1;
                    apply_setting(1, 1, -40, 511, 1, 31);
                end
                5: begin
                    rx_stall_pct <= 0;
                    pressure_on  <= 1'b0;
                    apply_setting(0, 1, -70, 1023, 8, 8);
                end
                6: begin
                    tx_idle_pct = 26;
                    rx_stall_pct <= 26;
                    apply_setting(1, 0, -int'($urandom_range(0, 128)), $urandom_range(0, 1023),
                                  $urandom_range(0, 31), $urandom_range(0, 31));
                end
                default: begin
                    tx_idle_pct = 87;
                    rx_stall_pct <= 0;
                    apply_setting($urandom_range(0, 1), $urandom_range(0, 1),
                                  -int'($urandom_range(0, 128)), $urandom_range(0, 1023),
                                  $urandom_range(0, 31), $urandom_range(0, 31));
                end
            endcase
            tick_pct = $urandom_range(3, 25);
            toa_bias = (int'($urandom_range(0, 8)) - 4) * 150;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                gap = 0;
                while (int'($urandom_range(0, 99)) < tx_idle_pct) begin
                    gap++;
                end
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end

                it.cmd = (int'($urandom_range(0, 99)) < tick_pct) ? CMD_TICK : CMD_MEAS;
                it.ch  = ($urandom_range(0, 99) < 85) ? CH_W'($urandom_range(0, 3))
                                                     : CH_W'($urandom_range(0, 63));
                roll = $urandom_range(0, 99);
                if (roll < 10) begin
                    rv = -128;
                end else if (roll < 15) begin
                    rv = DUMMY_LIMIT;
                end else if (roll < 20) begin
                    rv = 127;
                end else if (roll < 50) begin
                    rv = $urandom_range(0, 255);
                end else begin
                    rv = -100 + int'($urandom_range(0, 150));
                end
                it.rssi = RSSI_W'(rv);
                if ($urandom_range(0, 99) < 5) begin
                    tv = $urandom;
                end else begin
                    tv = toa_bias + int'($urandom_range(0, 400)) - 200;
                end
                it.toa = TOA_W'(tv);
                it.rep = ($urandom_range(0, 99) < 85) ? RTA_W'(adv_mem[it.ch])
                                                     : RTA_W'($urandom_range(0, 255));
                send_item(it, 1'b0, none);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_cnt == 0 && pending_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
